FILE: src/dlfe_pkg.sv
// ----------------------------------------------------------------------------
// dlfe_pkg
// Shared types, constants and the segment table for the LCD frame encoder.
// ----------------------------------------------------------------------------
package dlfe_pkg;

    localparam int unsigned VALUE_W     = 25;
    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned NUM_DIGITS  = 7;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [VALUE_W-1:0] OVER_LIMIT = 25'd10000000;

    // reciprocal of ten, exact for operands below 2**26 with a shift of 27
    localparam logic [23:0] RECIP_TEN   = 24'hCCCCCD;
    localparam int unsigned RECIP_SHIFT = 27;

    localparam logic [7:0] BYTE_ADDR  = 8'h70;
    localparam logic [7:0] BYTE_MODE  = 8'h48;
    localparam logic [7:0] BYTE_CMD   = 8'hE0;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_MINUS = 8'h20;
    localparam logic [7:0] BYTE_DP    = 8'h08;

    // position of each byte in the 22-byte request stream
    localparam logic [4:0] IDX_ADDR0  = 5'd0;
    localparam logic [4:0] IDX_MODE   = 5'd1;
    localparam logic [4:0] IDX_ADDR1  = 5'd2;
    localparam logic [4:0] IDX_CMD    = 5'd3;
    localparam logic [4:0] IDX_PTR    = 5'd4;
    localparam logic [4:0] IDX_DISP0  = 5'd5;
    localparam logic [4:0] IDX_LAST   = 5'd21;

    localparam logic [3:0] DISP_LAST  = 4'd15;
    localparam logic [3:0] PAD_BASE   = 4'd14;
    localparam logic [3:0] DP_POS     = 4'd2;

    // digits of one value, ready for the byte sequencer
    typedef struct packed {
        logic                  neg;
        logic                  ovf;
        logic [2:0]            top;
        logic [6:0][3:0]       digits;
    } dlfe_rec_t;

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] c;
        begin
            unique case (d)
                4'd0:    c = 8'hD7;
                4'd1:    c = 8'h03;
                4'd2:    c = 8'hB6;
                4'd3:    c = 8'hA7;
                4'd4:    c = 8'h63;
                4'd5:    c = 8'hE5;
                4'd6:    c = 8'hF5;
                4'd7:    c = 8'h07;
                4'd8:    c = 8'hF7;
                4'd9:    c = 8'hE7;
                default: c = 8'hD7;
            endcase
            return c;
        end
    endfunction

endpackage

FILE: src/dlfe_front.sv
// ----------------------------------------------------------------------------
// dlfe_front
// Takes a value, splits its magnitude into seven decimal digits, one per cycle.
// ----------------------------------------------------------------------------
module dlfe_front
    import dlfe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_W-1:0]     value_hundredths,
    output logic                   push_valid,
    input  logic                   push_ready,
    output dlfe_rec_t              push_rec
);

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_CONV = 2'd1;
    localparam logic [1:0] FS_PUSH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [2:0]       step_reg, step_next;
    logic [23:0]      t_reg, t_next;
    logic             neg_reg, neg_next;
    logic             ovf_reg, ovf_next;
    logic [6:0][3:0]  dig_reg, dig_next;

    logic [VALUE_W-1:0] mag;
    logic [47:0]        prod;
    logic [23:0]        quot;
    logic [23:0]        rem_full;
    logic [2:0]         top;

    assign mag      = value_hundredths[VALUE_W-1] ? (~value_hundredths + 25'd1)
                                                  : value_hundredths;
    assign prod     = 48'(t_reg) * 48'(RECIP_TEN);
    assign quot     = 24'(prod >> RECIP_SHIFT);
    assign rem_full = t_reg - ((quot << 3) + (quot << 1));

    always_comb
    begin
        priority if (dig_reg[6] != 4'd0) top = 3'd6;
        else if (dig_reg[5] != 4'd0)     top = 3'd5;
        else if (dig_reg[4] != 4'd0)     top = 3'd4;
        else if (dig_reg[3] != 4'd0)     top = 3'd3;
        else                             top = 3'd2;
    end

    assign s_tready        = (state_reg == FS_IDLE);
    assign push_valid      = (state_reg == FS_PUSH);
    assign push_rec.neg    = neg_reg;
    assign push_rec.ovf    = ovf_reg;
    assign push_rec.top    = top;
    assign push_rec.digits = dig_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        t_next     = t_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        dig_next   = dig_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (s_tvalid)
                begin
                    neg_next   = value_hundredths[VALUE_W-1];
                    ovf_next   = (mag >= OVER_LIMIT);
                    t_next     = mag[23:0];
                    step_next  = 3'd0;
                    state_next = FS_CONV;
                end
            end
            FS_CONV:
            begin
                dig_next[step_reg] = rem_full[3:0];
                t_next             = quot;
                step_next          = step_reg + 3'd1;
                if (step_reg == 3'(NUM_DIGITS - 1))
                begin
                    state_next = FS_PUSH;
                end
            end
            FS_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            step_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
        dig_reg <= dig_next;
    end

endmodule

FILE: src/dlfe_fifo.sv
// ----------------------------------------------------------------------------
// dlfe_fifo
// Short queue of digit records between the converter and the byte sequencer.
// ----------------------------------------------------------------------------
module dlfe_fifo
    import dlfe_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  dlfe_rec_t  push_rec,
    output logic       pop_valid,
    input  logic       pop_ready,
    output dlfe_rec_t  pop_rec
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

    dlfe_rec_t        mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_MAX);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_rec    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

FILE: src/dlfe_back.sv
// ----------------------------------------------------------------------------
// dlfe_back
// Byte sequencer: walks the 22-byte request stream for one digit record.
// ----------------------------------------------------------------------------
module dlfe_back
    import dlfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  dlfe_rec_t         pop_rec,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    logic              active_reg, active_next;
    logic [4:0]        idx_reg, idx_next;
    dlfe_rec_t         cur_reg;
    logic              ovalid_reg;
    logic [7:0]        obyte_reg;
    logic [1:0]        ouser_reg;
    logic              olast_reg;

    logic              advance;
    logic              load;
    logic [7:0]        byte_c;
    logic              start_c, stop_c, last_c;
    logic [3:0]        disp_j;
    logic [3:0]        pad;
    logic [3:0]        pos;
    logic [7:0]        disp_c;
    logic [7:0]        seg_c;

    assign advance   = !ovalid_reg || m_tready;
    assign load      = advance && pop_valid && (!active_reg || idx_reg == IDX_LAST);
    assign pop_ready = load;

    assign disp_j = 4'(idx_reg - IDX_DISP0);
    assign pad    = PAD_BASE - {1'b0, cur_reg.top};
    assign pos    = DISP_LAST - disp_j;
    assign seg_c  = seg_code(cur_reg.digits[pos[2:0]])
                    | ((pos == DP_POS) ? BYTE_DP : BYTE_ZERO);

    always_comb
    begin
        priority if (cur_reg.ovf) disp_c = BYTE_MINUS;
        else if (disp_j < pad)    disp_c = BYTE_ZERO;
        else if (disp_j == pad)   disp_c = cur_reg.neg ? BYTE_MINUS : BYTE_ZERO;
        else                      disp_c = seg_c;
    end

    always_comb
    begin
        start_c = 1'b0;
        stop_c  = 1'b0;
        last_c  = 1'b0;
        unique case (idx_reg)
            IDX_ADDR0:
            begin
                byte_c  = BYTE_ADDR;
                start_c = 1'b1;
            end
            IDX_MODE:
            begin
                byte_c = BYTE_MODE;
                stop_c = 1'b1;
            end
            IDX_ADDR1:
            begin
                byte_c  = BYTE_ADDR;
                start_c = 1'b1;
            end
            IDX_CMD:  byte_c = BYTE_CMD;
            IDX_PTR:  byte_c = BYTE_ZERO;
            IDX_LAST:
            begin
                byte_c = BYTE_ZERO;
                stop_c = 1'b1;
                last_c = 1'b1;
            end
            default:  byte_c = disp_c;
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (advance)
        begin
            if (active_reg && idx_reg != IDX_LAST)
            begin
                idx_next = idx_reg + 5'd1;
            end
            else if (load)
            begin
                active_next = 1'b1;
                idx_next    = IDX_ADDR0;
            end
            else
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= IDX_ADDR0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            if (advance)
            begin
                ovalid_reg <= active_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= pop_rec;
        end
        if (advance && active_reg)
        begin
            obyte_reg <= byte_c;
            ouser_reg <= {stop_c, start_c};
            olast_reg <= last_c;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = obyte_reg;
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

endmodule

FILE: src/decimal_lcd_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// decimal_lcd_frame_encoder_core
// Turns a signed value in hundredths into the 22-byte LCD request stream.
// ----------------------------------------------------------------------------
// Input channel s_*: one request per value, value_hundredths in s_tdata[24:0].
// Output channel m_*: 22 requests per value, one byte each. m_tuser[0] asks
// for a start condition before the byte, m_tuser[1] for a stop after it,
// m_tlast marks the final byte of the run.
// The front splits the magnitude into seven digits, one digit per cycle
// through a reciprocal multiply by one tenth; s_tready is low from accept
// until the record is pushed, so no new value is taken before then.
// A two-entry queue decouples it from the byte sequencer, which emits
// one byte per cycle from an output register while m_tready is high. The
// first byte passes through the sequencer's record and index registers and
// then its output register; the sequencer loads the following record as it
// emits the final byte of the current one, so back-to-back values run gapless.
// Reset clears the converter, queue and sequencer; no clearing pass.
// A stalled receiver holds the output register; the sequencer and then the
// queue fill, after which s_tready stays low until space frees up.
// ----------------------------------------------------------------------------
module decimal_lcd_frame_encoder_core
    import dlfe_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // [24:0] value_hundredths
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
    output logic [1:0]            m_tuser,   // [0] start_before, [1] stop_after
    output logic                  m_tlast
);

    logic       push_valid, push_ready;
    logic       pop_valid, pop_ready;
    dlfe_rec_t  push_rec, pop_rec;
    logic [IN_TDATA_W-VALUE_W-1:0] unused_pad;

    assign unused_pad = s_tdata[IN_TDATA_W-1:VALUE_W];

    dlfe_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .value_hundredths (s_tdata[VALUE_W-1:0]),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_rec         (push_rec)
    );

    dlfe_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    dlfe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_rec   (pop_rec),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
